// File: rtl/lcf_pkg.sv
// Package for the LSTM cell update: number format, activation tables and rounding helpers.
package lcf_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int FRAC_BITS    = 12;
  localparam int ACT_SEGMENTS = 64;

  // Activation domain is [-2^ACT_H, 2^ACT_H - 1]; segments split it evenly.
  localparam int ACT_H    = (FRAC_BITS + 4 < DATA_WIDTH - 1) ? FRAC_BITS + 4 : DATA_WIDTH - 1;
  localparam int SEG_BITS = $clog2(ACT_SEGMENTS);
  localparam int T_BITS   = ACT_H + 1 - SEG_BITS;
  localparam int PROD_W   = DATA_WIDTH + T_BITS + 2;
  localparam int ACC_W    = 2 * DATA_WIDTH + 1;

  localparam int    WBITS = 30;
  localparam longint WONE = longint'(1) <<< WBITS;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [DATA_WIDTH:0]   delta_t;
  typedef logic        [SEG_BITS-1:0]   seg_t;
  typedef logic        [T_BITS-1:0]     frac_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [2*DATA_WIDTH-1:0] wide_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

  typedef data_t  base_tab_t  [ACT_SEGMENTS];
  typedef delta_t delta_tab_t [ACT_SEGMENTS];

  localparam data_t ACT_HI = data_t'((longint'(1) <<< ACT_H) - 1);
  localparam data_t ACT_LO = data_t'(-(longint'(1) <<< ACT_H));
  localparam acc_t  SAT_HI = acc_t'((longint'(1) <<< (DATA_WIDTH - 1)) - 1);
  localparam acc_t  SAT_LO = acc_t'(-(longint'(1) <<< (DATA_WIDTH - 1)));
  localparam acc_t  RND    = acc_t'(longint'(1) <<< (FRAC_BITS - 1));

  // Floored quotient of two non-negative values, by shift and subtract.
  function automatic longint udiv(longint num, longint den);
    longint q;
    longint r;
    begin
      q = 0;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
        r = (r <<< 1) | ((num >>> b) & longint'(1));
        if (r >= den) begin
          r = r - den;
          q = q | (longint'(1) <<< b);
        end
      end
      return q;
    end
  endfunction

  // exp(-y) in Q30 for a Q30 argument y >= 0: Taylor series on y/64, then six squarings.
  function automatic longint exp_neg(longint y30);
    longint z;
    longint term;
    longint sum;
    bit     done;
    begin
      if (y30 >= (longint'(24) <<< WBITS)) begin
        return 0;
      end
      z    = (y30 + 32) >>> 6;
      sum  = WONE;
      term = WONE;
      done = 1'b0;
      for (int n = 1; n < 40; n++) begin
        if (!done) begin
          term = udiv((term * z) >>> WBITS, longint'(n));
          if (term == 0) begin
            done = 1'b1;
          end else if (n[0]) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > WONE) begin
        sum = WONE;
      end
      for (int k = 0; k < 6; k++) begin
        sum = (sum * sum + (WONE >>> 1)) >>> WBITS;
      end
      return sum;
    end
  endfunction

  function automatic longint q30_to_q(longint v);
    begin
      return (v + (longint'(1) <<< (WBITS - 1 - FRAC_BITS))) >>> (WBITS - FRAC_BITS);
    end
  endfunction

  // Exact function value at knot position p, rounded to the data format and saturated.
  function automatic longint knot_val(bit is_tanh, longint p);
    longint a;
    longint y30;
    longint e;
    longint r;
    longint hi;
    begin
      a   = (p < 0) ? -p : p;
      y30 = a <<< (WBITS - FRAC_BITS);
      if (is_tanh) begin
        e = exp_neg(y30 * 2);
        r = q30_to_q(udiv((WONE - e) * WONE, WONE + e));
        if (p < 0) begin
          r = -r;
        end
      end else begin
        e = exp_neg(y30);
        r = udiv(WONE * WONE, WONE + e);
        if (p < 0) begin
          r = WONE - r;
        end
        r = q30_to_q(r);
      end
      hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
      if (r > hi) begin
        r = hi;
      end
      if (r < -hi - 1) begin
        r = -hi - 1;
      end
      return r;
    end
  endfunction

  function automatic longint knot_pos(int k);
    begin
      return (longint'(k) <<< T_BITS) - (longint'(1) <<< ACT_H);
    end
  endfunction

  function automatic base_tab_t build_base(bit is_tanh);
    base_tab_t tab;
    begin
      for (int k = 0; k < ACT_SEGMENTS; k++) begin
        tab[k] = data_t'(knot_val(is_tanh, knot_pos(k)));
      end
      return tab;
    end
  endfunction

  function automatic delta_tab_t build_delta(bit is_tanh);
    delta_tab_t tab;
    begin
      for (int k = 0; k < ACT_SEGMENTS; k++) begin
        tab[k] = delta_t'(knot_val(is_tanh, knot_pos(k + 1)) - knot_val(is_tanh, knot_pos(k)));
      end
      return tab;
    end
  endfunction

  localparam base_tab_t  SIG_BASE   = build_base(1'b0);
  localparam delta_tab_t SIG_DELTA  = build_delta(1'b0);
  localparam base_tab_t  TANH_BASE  = build_base(1'b1);
  localparam delta_tab_t TANH_DELTA = build_delta(1'b1);

  // Round a product sum to FRAC_BITS (half up, floor shift).
  function automatic acc_t round_acc(acc_t v);
    begin
      return (v + RND) >>> FRAC_BITS;
    end
  endfunction

  function automatic data_t sat_data(acc_t v);
    begin
      if (v > SAT_HI) begin
        return data_t'(SAT_HI);
      end else if (v < SAT_LO) begin
        return data_t'(SAT_LO);
      end
      return data_t'(v);
    end
  endfunction

  function automatic logic is_clipped(acc_t v);
    begin
      return (v > SAT_HI) || (v < SAT_LO);
    end
  endfunction

endpackage

// File: rtl/lcf_act.sv
// Three-stage piecewise-linear sigmoid or tanh: table lookup, slope multiply, add.
module lcf_act (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tanh_i,
  input  logic          valid_i,
  input  lcf_pkg::data_t x_i,
  output logic          valid_o,
  output lcf_pkg::data_t y_o
);
  import lcf_pkg::*;

  data_t  x_clamp;
  logic [ACT_H:0] u_idx;
  seg_t   seg;

  data_t  base1_q, base2_q, y_q;
  delta_t delta1_q;
  frac_t  frac1_q;
  prod_t  prod2_q;
  logic   v1_q, v2_q, v3_q;

  prod_t  prod_adj;
  prod_t  quot;
  prod_t  sum_d;

  always_comb begin
    if (x_i < ACT_LO) begin
      x_clamp = ACT_LO;
    end else if (x_i > ACT_HI) begin
      x_clamp = ACT_HI;
    end else begin
      x_clamp = x_i;
    end
    // Offset by 2^ACT_H: flip the top bit of the in-range two's complement value.
    u_idx = {~x_clamp[ACT_H], x_clamp[ACT_H-1:0]};
    seg   = u_idx[ACT_H -: SEG_BITS];
  end

  // Quotient truncates toward zero, as the interpolation is defined.
  always_comb begin
    prod_adj = prod2_q + (prod2_q[PROD_W-1] ? prod_t'((1 << T_BITS) - 1) : prod_t'(0));
    quot     = prod_adj >>> T_BITS;
    sum_d    = quot + prod_t'(base2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    base1_q  <= tanh_i ? TANH_BASE[seg] : SIG_BASE[seg];
    delta1_q <= tanh_i ? TANH_DELTA[seg] : SIG_DELTA[seg];
    frac1_q  <= u_idx[T_BITS-1:0];
    prod2_q  <= prod_t'(delta1_q * $signed({1'b0, frac1_q}));
    base2_q  <= base1_q;
    y_q      <= sum_d[DATA_WIDTH-1:0];
  end

  assign valid_o = v3_q;
  assign y_o     = y_q;

endmodule

// File: rtl/lcf_cell.sv
// Two-stage cell update: forget and input products, then rounded sum with saturation.
module lcf_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic          keep_i,
  input  lcf_pkg::data_t gate_i_i,
  input  lcf_pkg::data_t gate_f_i,
  input  lcf_pkg::data_t gate_g_i,
  input  lcf_pkg::data_t cell_prev_i,
  output logic          valid_o,
  output lcf_pkg::data_t cell_o,
  output logic          clip_o
);
  import lcf_pkg::*;

  data_t gate_f_eff;
  wide_t prod_fc_q, prod_ig_q;
  acc_t  acc_r;
  data_t cell_q;
  logic  clip_q;
  logic  v1_q, v2_q;

  // A sequence restart drops the forget gate to zero.
  assign gate_f_eff = keep_i ? gate_f_i : '0;

  always_comb begin
    acc_r = round_acc(acc_t'(prod_fc_q) + acc_t'(prod_ig_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_fc_q <= gate_f_eff * cell_prev_i;
    prod_ig_q <= gate_i_i * gate_g_i;
    cell_q    <= sat_data(acc_r);
    clip_q    <= is_clipped(acc_r);
  end

  assign valid_o = v2_q;
  assign cell_o  = cell_q;
  assign clip_o  = clip_q;

endmodule

// File: rtl/lstm_cell_forward.sv
// Top level of the pipelined pointwise LSTM cell update.
// Usage: one request carries the four gate pre-activations, the previous cell value and the
// keep flag, all signed Q3.12. A request is taken at every clock edge where start is high;
// busy is held low because the pipeline never stalls, so a new request can follow every
// cycle and the sustained rate is one element per clock. Each request produces exactly one
// result, shown for one cycle with done_o high. The receiver cannot hold results off, so
// it must take every cycle in which done_o is high. The pipeline is the chain of units:
// three stages for the gate activations (lookup, slope multiply, add), two for the cell
// product sum and saturation, three for tanh of the new cell, and two for the output gate
// product and its rounding. cell_saturated_o flags a clipped cell value; a clipped hidden
// value is saturated silently.
module lstm_cell_forward (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  lcf_pkg::data_t gate_input_pre_i,
  input  lcf_pkg::data_t gate_forget_pre_i,
  input  lcf_pkg::data_t gate_output_pre_i,
  input  lcf_pkg::data_t gate_cand_pre_i,
  input  lcf_pkg::data_t cell_prev_i,
  input  logic           keep_flag_i,
  output logic           done_o,
  output lcf_pkg::data_t hidden_out_o,
  output lcf_pkg::data_t cell_out_o,
  output logic           cell_saturated_o
);
  import lcf_pkg::*;

  localparam int GO_DLY = 5;
  localparam int C_DLY  = 3;

  logic  in_valid;
  logic  vi, vf, vo, vg;
  data_t gi, gf, go, gg;

  // Side data aligned with the activation stages.
  data_t cp_q [3];
  logic  keep_q [3];

  // Output gate waits for tanh of the new cell.
  data_t go_q [GO_DLY];

  logic  vc;
  data_t cell_new;
  logic  clip_new;
  data_t c_q [C_DLY];
  logic  clip_q [C_DLY];

  logic  vt;
  data_t tc;

  wide_t prod_h_q;
  data_t c_h_q;
  logic  clip_h_q;
  logic  vh_q;

  acc_t  h_acc;
  logic  done_q;
  data_t hidden_q, cell_out_q;
  logic  sat_q;

  // Nothing downstream can push back, so requests are always welcome.
  assign busy     = 1'b0;
  assign in_valid = start;

  lcf_act u_act_i (
    .clk_i, .rst_ni, .tanh_i(1'b0), .valid_i(in_valid), .x_i(gate_input_pre_i),
    .valid_o(vi), .y_o(gi)
  );
  lcf_act u_act_f (
    .clk_i, .rst_ni, .tanh_i(1'b0), .valid_i(in_valid), .x_i(gate_forget_pre_i),
    .valid_o(vf), .y_o(gf)
  );
  lcf_act u_act_o (
    .clk_i, .rst_ni, .tanh_i(1'b0), .valid_i(in_valid), .x_i(gate_output_pre_i),
    .valid_o(vo), .y_o(go)
  );
  lcf_act u_act_g (
    .clk_i, .rst_ni, .tanh_i(1'b1), .valid_i(in_valid), .x_i(gate_cand_pre_i),
    .valid_o(vg), .y_o(gg)
  );

  always_ff @(posedge clk_i) begin
    cp_q[0]   <= cell_prev_i;
    keep_q[0] <= keep_flag_i;
    for (int k = 1; k < 3; k++) begin
      cp_q[k]   <= cp_q[k-1];
      keep_q[k] <= keep_q[k-1];
    end
    go_q[0] <= go;
    for (int k = 1; k < GO_DLY; k++) begin
      go_q[k] <= go_q[k-1];
    end
  end

  // All four gate activations finish in the same cycle.
  lcf_cell u_cell (
    .clk_i, .rst_ni,
    .valid_i(vi & vf & vo & vg),
    .keep_i(keep_q[2]),
    .gate_i_i(gi),
    .gate_f_i(gf),
    .gate_g_i(gg),
    .cell_prev_i(cp_q[2]),
    .valid_o(vc),
    .cell_o(cell_new),
    .clip_o(clip_new)
  );

  lcf_act u_act_c (
    .clk_i, .rst_ni, .tanh_i(1'b1), .valid_i(vc), .x_i(cell_new),
    .valid_o(vt), .y_o(tc)
  );

  always_ff @(posedge clk_i) begin
    c_q[0]    <= cell_new;
    clip_q[0] <= clip_new;
    for (int k = 1; k < C_DLY; k++) begin
      c_q[k]    <= c_q[k-1];
      clip_q[k] <= clip_q[k-1];
    end
  end

  // Hidden value: output gate times tanh of the saturated cell, rounded and saturated.
  always_ff @(posedge clk_i) begin
    prod_h_q <= go_q[GO_DLY-1] * tc;
    c_h_q    <= c_q[C_DLY-1];
    clip_h_q <= clip_q[C_DLY-1];
  end

  always_comb begin
    h_acc = round_acc(acc_t'(prod_h_q));
  end

  always_ff @(posedge clk_i) begin
    hidden_q   <= sat_data(h_acc);
    cell_out_q <= c_h_q;
    sat_q      <= clip_h_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vh_q   <= vt;
      done_q <= vh_q;
    end
  end

  assign done_o           = done_q;
  assign hidden_out_o     = hidden_q;
  assign cell_out_o       = cell_out_q;
  assign cell_saturated_o = sat_q;

endmodule
